### src/websocket_client_frame_deframer_defines.svh
// assertion macros for the websocket client frame deframer
`ifndef WEBSOCKET_CLIENT_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_CLIENT_FRAME_DEFRAMER_DEFINES_SVH

// property that must hold at every rising clock edge outside reset
`define WSCFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after its trigger
`define WSCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/wscfd_pkg.sv
// types and constants of the websocket client frame deframer
`default_nettype none

package wscfd_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DEAD    = 3'd5
    } t_phase;

    // result event codes
    typedef enum logic [2:0] {
        EV_TEXT     = 3'd0,
        EV_PONG     = 3'd1,
        EV_CLOSE    = 3'd2,
        EV_UNMASKED = 3'd3,
        EV_TOOLONG  = 3'd4,
        EV_OVERFLOW = 3'd5,
        EV_TIMEOUT  = 3'd6
    } t_event;

    // input beat kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // frame opcodes
    localparam logic [3:0] OPC_CONT   = 4'h0;
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;

    // header length codes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // register map and reset values
    localparam logic REG_IDLE_TIMEOUT = 1'b0;
    localparam logic REG_MAX_MESSAGE  = 1'b1;
    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd15000;
    localparam logic [8:0]  MAX_MESSAGE_RST  = 9'd511;

    // one result beat
    typedef struct packed {
        logic       last;
        logic       dv;
        logic [7:0] data;
        t_event     ev;
    } t_result;

endpackage

`default_nettype wire

### src/websocket_client_frame_deframer.sv
// websocket client frame deframer top level
//
// Input stream: one beat per item, s_tuser holds the kind (byte, one
// millisecond tick, connection start) and s_tdata the received byte.
// Output stream: one beat per event, m_tuser holds the event code and the
// data valid flag, m_tdata the unmasked payload byte, m_tlast marks the end
// of a text message or of a pong payload.
// APB port: register 0 idle timeout in ticks at 0x0, register 1 largest
// message length at 0x4; they are to be written only while the stream is
// idle, which the block does not enforce. Each beat is parsed in the cycle it
// is accepted; its result, if any, is registered for m_tvalid. The output
// register is backed by a one-entry skid stage, so a beat is still taken while
// a result waits: one beat is taken every cycle, and s_tready drops only while
// the skid is full. After reset the link is dead until a connection start
// beat; registers return to 15000 ticks and 511 bytes. A stalled receiver
// holds m_tdata, m_tuser and m_tlast steady until the beat is taken.
`default_nettype none

`include "websocket_client_frame_deframer_defines.svh"

module websocket_client_frame_deframer #(
    parameter int BUFFER_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // output stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata,   // [7:0] data
    output      logic [3:0]  m_tuser,   // [2:0] event_res, [3] data_valid
    output      logic        m_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int BUF_LIM = BUFFER_BYTES - 1;

    // configuration registers
    logic [15:0] r_tmo;
    logic [8:0]  r_maxb;

    // parser state
    wscfd_pkg::t_phase r_phase, n_phase;
    logic        r_fin, n_fin;
    logic [3:0]  r_opc, n_opc;
    logic        r_masked, n_masked;
    logic [3:0]  r_lbl, n_lbl;
    logic [9:0]  r_plen, n_plen;
    logic        r_pbig, n_pbig;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_kcnt, n_kcnt;
    logic [8:0]  r_pcnt, n_pcnt;
    logic [9:0]  r_mlen, n_mlen;
    logic        r_text, n_text;
    logic [15:0] r_idle, n_idle;

    // output register and skid stage
    logic                 r_ov, r_sv;
    wscfd_pkg::t_result   r_od, r_sd;

    logic                 w_acc;
    logic                 w_res_v;
    wscfd_pkg::t_result   w_res;
    logic [8:0]           w_lim;

    assign w_acc = s_tvalid && s_tready;

    // effective size limit
    always_comb begin
        if ({3'b000, r_maxb} > 12'(BUF_LIM)) begin
            w_lim = 9'(BUF_LIM);
        end else begin
            w_lim = r_maxb;
        end
    end

    // configuration write and read back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo  <= wscfd_pkg::IDLE_TIMEOUT_RST;
            r_maxb <= wscfd_pkg::MAX_MESSAGE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                wscfd_pkg::REG_IDLE_TIMEOUT: r_tmo  <= pwdata[15:0];
                wscfd_pkg::REG_MAX_MESSAGE:  r_maxb <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            wscfd_pkg::REG_IDLE_TIMEOUT: prdata = {16'd0, r_tmo};
            wscfd_pkg::REG_MAX_MESSAGE:  prdata = {23'd0, r_maxb};
            default:                     prdata = 32'd0;
        endcase
    end

    // next state and result of one accepted beat
    always_comb begin
        logic        do_cmp;
        logic        c_have;
        logic [7:0]  c_d;
        logic        do_after;
        logic        a_masked;
        logic [3:0]  lbl_dec;
        logic [1:0]  kcnt_inc;
        logic [8:0]  pcnt_inc;
        logic [10:0] msum;
        logic [7:0]  kbyte;

        n_phase  = r_phase;
        n_fin    = r_fin;
        n_opc    = r_opc;
        n_masked = r_masked;
        n_lbl    = r_lbl;
        n_plen   = r_plen;
        n_pbig   = r_pbig;
        n_key    = r_key;
        n_kcnt   = r_kcnt;
        n_pcnt   = r_pcnt;
        n_mlen   = r_mlen;
        n_text   = r_text;
        n_idle   = r_idle;
        w_res_v  = 1'b0;
        w_res    = '{last: 1'b0, dv: 1'b0, data: 8'd0, ev: wscfd_pkg::EV_TEXT};
        do_cmp   = 1'b0;
        c_have   = 1'b0;
        c_d      = 8'd0;
        do_after = 1'b0;
        a_masked = r_masked;
        lbl_dec  = r_lbl - 4'd1;
        kcnt_inc = r_kcnt + 2'd1;
        pcnt_inc = r_pcnt + 9'd1;
        msum     = {1'b0, r_mlen} + {1'b0, r_plen};

        case (r_pcnt[1:0])
            2'd0:    kbyte = r_key[31:24];
            2'd1:    kbyte = r_key[23:16];
            2'd2:    kbyte = r_key[15:8];
            default: kbyte = r_key[7:0];
        endcase

        if (w_acc) begin
            case (s_tuser)
                wscfd_pkg::KIND_START: begin
                    n_phase  = wscfd_pkg::PH_HDR0;
                    n_fin    = 1'b0;
                    n_opc    = 4'd0;
                    n_masked = 1'b0;
                    n_lbl    = 4'd0;
                    n_plen   = 10'd0;
                    n_pbig   = 1'b0;
                    n_key    = 32'd0;
                    n_kcnt   = 2'd0;
                    n_pcnt   = 9'd0;
                    n_mlen   = 10'd0;
                    n_text   = 1'b0;
                    n_idle   = 16'd0;
                end
                wscfd_pkg::KIND_TICK: begin
                    if (r_phase != wscfd_pkg::PH_DEAD) begin
                        if (r_idle >= r_tmo) begin
                            n_phase  = wscfd_pkg::PH_DEAD;
                            w_res_v  = 1'b1;
                            w_res.ev = wscfd_pkg::EV_TIMEOUT;
                        end else begin
                            n_idle = r_idle + 16'd1;
                        end
                    end
                end
                wscfd_pkg::KIND_BYTE: begin
                    case (r_phase)
                        wscfd_pkg::PH_HDR0: begin
                            n_fin   = s_tdata[7];
                            n_opc   = s_tdata[3:0];
                            n_phase = wscfd_pkg::PH_HDR1;
                        end
                        wscfd_pkg::PH_HDR1: begin
                            n_masked = s_tdata[7];
                            a_masked = s_tdata[7];
                            n_plen   = 10'd0;
                            n_pbig   = 1'b0;
                            if (s_tdata[6:0] == wscfd_pkg::LEN_EXT16) begin
                                n_lbl   = 4'd2;
                                n_phase = wscfd_pkg::PH_EXT;
                            end else if (s_tdata[6:0] == wscfd_pkg::LEN_EXT64) begin
                                n_lbl   = 4'd8;
                                n_phase = wscfd_pkg::PH_EXT;
                            end else begin
                                n_plen   = {3'b000, s_tdata[6:0]};
                                do_after = 1'b1;
                            end
                        end
                        wscfd_pkg::PH_EXT: begin
                            // keep ten low bits, fold the rest into a sticky flag
                            n_plen = {r_plen[1:0], s_tdata};
                            n_pbig = r_pbig || (r_plen[9:2] != 8'd0);
                            n_lbl  = lbl_dec;
                            if (lbl_dec == 4'd0) begin
                                do_after = 1'b1;
                            end
                        end
                        wscfd_pkg::PH_MASK: begin
                            n_key  = {r_key[23:0], s_tdata};
                            n_kcnt = kcnt_inc;
                            if (kcnt_inc == 2'd0) begin
                                if (r_pbig || (r_plen > {1'b0, w_lim})) begin
                                    n_phase  = wscfd_pkg::PH_DEAD;
                                    w_res_v  = 1'b1;
                                    w_res.ev = wscfd_pkg::EV_TOOLONG;
                                end else if ((r_opc == wscfd_pkg::OPC_CONT ||
                                              r_opc == wscfd_pkg::OPC_TEXT) &&
                                             (msum > {2'b00, w_lim})) begin
                                    n_phase  = wscfd_pkg::PH_DEAD;
                                    w_res_v  = 1'b1;
                                    w_res.ev = wscfd_pkg::EV_OVERFLOW;
                                end else begin
                                    if (r_opc == wscfd_pkg::OPC_CONT ||
                                        r_opc == wscfd_pkg::OPC_TEXT) begin
                                        n_mlen = msum[9:0];
                                        if (r_opc == wscfd_pkg::OPC_TEXT) begin
                                            n_text = 1'b1;
                                        end
                                    end else if (r_opc == wscfd_pkg::OPC_BINARY) begin
                                        n_text = 1'b0;
                                    end
                                    n_pcnt = 9'd0;
                                    if (r_plen == 10'd0) begin
                                        do_cmp = 1'b1;
                                    end else begin
                                        n_phase = wscfd_pkg::PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                        wscfd_pkg::PH_PAYLOAD: begin
                            c_d    = s_tdata ^ kbyte;
                            n_pcnt = pcnt_inc;
                            if ({1'b0, pcnt_inc} >= r_plen) begin
                                do_cmp = 1'b1;
                                c_have = 1'b1;
                            end else if (r_opc == wscfd_pkg::OPC_PING) begin
                                w_res_v = 1'b1;
                                w_res   = '{last: 1'b0, dv: 1'b1, data: c_d,
                                            ev: wscfd_pkg::EV_PONG};
                            end else if ((r_opc == wscfd_pkg::OPC_CONT ||
                                          r_opc == wscfd_pkg::OPC_TEXT) && r_text) begin
                                w_res_v = 1'b1;
                                w_res   = '{last: 1'b0, dv: 1'b1, data: c_d,
                                            ev: wscfd_pkg::EV_TEXT};
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // length known: the frame must carry a mask key
        if (do_after) begin
            if (!a_masked) begin
                n_phase  = wscfd_pkg::PH_DEAD;
                w_res_v  = 1'b1;
                w_res.ev = wscfd_pkg::EV_UNMASKED;
            end else begin
                n_key   = 32'd0;
                n_kcnt  = 2'd0;
                n_phase = wscfd_pkg::PH_MASK;
            end
        end

        // frame end
        if (do_cmp) begin
            n_idle  = 16'd0;
            n_phase = wscfd_pkg::PH_HDR0;
            if (r_opc == wscfd_pkg::OPC_CLOSE) begin
                n_phase  = wscfd_pkg::PH_DEAD;
                w_res_v  = 1'b1;
                w_res    = '{last: 1'b0, dv: 1'b0, data: 8'd0, ev: wscfd_pkg::EV_CLOSE};
            end else if (r_opc == wscfd_pkg::OPC_PING) begin
                w_res_v = 1'b1;
                w_res   = '{last: 1'b1, dv: c_have, data: c_d, ev: wscfd_pkg::EV_PONG};
            end else if (r_opc == wscfd_pkg::OPC_CONT || r_opc == wscfd_pkg::OPC_TEXT) begin
                if (n_text && (c_have || r_fin)) begin
                    w_res_v = 1'b1;
                    w_res   = '{last: r_fin, dv: c_have, data: c_d,
                                ev: wscfd_pkg::EV_TEXT};
                end
                if (r_fin) begin
                    n_mlen = 10'd0;
                    n_text = 1'b0;
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wscfd_pkg::PH_DEAD;
            r_fin    <= 1'b0;
            r_opc    <= 4'd0;
            r_masked <= 1'b0;
            r_lbl    <= 4'd0;
            r_plen   <= 10'd0;
            r_pbig   <= 1'b0;
            r_key    <= 32'd0;
            r_kcnt   <= 2'd0;
            r_pcnt   <= 9'd0;
            r_mlen   <= 10'd0;
            r_text   <= 1'b0;
            r_idle   <= 16'd0;
        end else begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_opc    <= n_opc;
            r_masked <= n_masked;
            r_lbl    <= n_lbl;
            r_plen   <= n_plen;
            r_pbig   <= n_pbig;
            r_key    <= n_key;
            r_kcnt   <= n_kcnt;
            r_pcnt   <= n_pcnt;
            r_mlen   <= n_mlen;
            r_text   <= n_text;
            r_idle   <= n_idle;
        end
    end

    // output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || m_tready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= w_res_v;
            end
        end else if (w_res_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || m_tready) begin
            if (r_sv) begin
                r_od <= r_sd;
            end else if (w_res_v) begin
                r_od <= w_res;
            end
        end else if (w_res_v) begin
            r_sd <= w_res;
        end
    end

    // port outputs
    always_comb begin
        s_tready = !r_sv;
        m_tvalid = r_ov;
        m_tdata  = r_od.data;
        m_tuser  = {r_od.dv, r_od.ev};
        m_tlast  = r_od.last;
    end

    // checks
    `WSCFD_ASSERT(a_skid_behind_out, i_clk, i_rst_n, (r_sv |-> r_ov), "skid full with output empty")
    `WSCFD_ASSERT(a_payload_in_range, i_clk, i_rst_n, ((r_phase == wscfd_pkg::PH_PAYLOAD) |-> (!r_pbig && (10'(r_pcnt) < r_plen))), "payload count past frame length")
    `WSCFD_ASSERT_NEXT(a_start_opens_link, i_clk, i_rst_n, (w_acc && (s_tuser == wscfd_pkg::KIND_START)), ((r_phase == wscfd_pkg::PH_HDR0) && (r_idle == 16'd0)), "connection start did not reset the parser")

endmodule

`default_nettype wire
